// File: rtl/lcg_pkg.sv
// Shared constants, register indexes and types of the linear chirp generator.
package lcg_pkg;

	// Default widths of the datapath
	localparam int PHASE_BITS_DEF      = 32;
	localparam int TABLE_ADDR_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 16;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Quarter turn in radians, Q30
	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_PHASE     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_INCREMENT = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INCREMENT_STEP  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CHIRP_LENGTH    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_MODE     = 3'd4;

	// Register reset values
	localparam logic [15:0] CHIRP_LENGTH_RST = 16'd5000;

	// Per-sample classification handed from front to back
	typedef struct packed {
		logic last;
		logic done;
	} lcg_flags_t;

	localparam int FLAGS_BITS = $bits(lcg_flags_t);

endpackage

// File: rtl/linear_chirp_generator.sv
// Linear chirp generator top level: front, queue and back connected.
// Path: a transferred tick passes the queue, the mirroring and table read stages and the output register.
// Throughput: one sample per clock while neither channel stalls, as the phase accumulator updates on every transfer.
// Backpressure on the sample channel fills a four-entry queue before tick stalls.
// Reset: registers take their reset values, chirp state clears, queue and pipeline empty.
// The cosine table is constant, so no clearing pass follows reset.
module linear_chirp_generator #(
	parameter int PHASE_BITS      = lcg_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = lcg_pkg::TABLE_ADDR_BITS_DEF,
	parameter int SAMPLE_BITS     = lcg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lcg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [31:0]                       cfg_data,
	// tick channel
	input  logic                              tick_valid,
	output logic                              tick_stall,
	input  logic                              tick,
	// sample channel
	output logic                              sample_valid,
	input  logic                              sample_stall,
	output logic signed [SAMPLE_BITS-1:0]     sample,
	output logic                              chirp_end,
	output logic                              done_res
);
	import lcg_pkg::*;

	localparam int ENTRY_BITS = TABLE_ADDR_BITS + 2 + FLAGS_BITS;

	logic                       q_push;
	logic                       q_pop;
	logic                       q_full;
	logic                       q_empty;
	logic [TABLE_ADDR_BITS+1:0] wr_phase;
	lcg_flags_t                 wr_flags;
	logic [ENTRY_BITS-1:0]      wr_entry;
	logic [ENTRY_BITS-1:0]      rd_entry;

	// Registers accept every write
	assign cfg_ready = 1'b1;

	lcg_front #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tick_valid (tick_valid),
		.tick       (tick),
		.tick_stall (tick_stall),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_phase    (wr_phase),
		.q_flags    (wr_flags)
	);

	assign wr_entry = {wr_phase, wr_flags};

	lcg_queue #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (wr_entry),
		.pop    (q_pop),
		.rdata  (rd_entry),
		.full   (q_full),
		.empty  (q_empty)
	);

	lcg_back #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_phase      (rd_entry[ENTRY_BITS-1:FLAGS_BITS]),
		.q_flags      (lcg_flags_t'(rd_entry[FLAGS_BITS-1:0])),
		.q_pop        (q_pop),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.chirp_end    (chirp_end),
		.done_res     (done_res)
	);

endmodule

// File: rtl/lcg_front.sv
// Front part: configuration registers, chirp sequencing and phase accumulation.
module lcg_front #(
	parameter int PHASE_BITS      = lcg_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = lcg_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_valid,
	input  logic [lcg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [31:0]                       cfg_data,
	// tick channel
	input  logic                              tick_valid,
	input  logic                              tick,
	output logic                              tick_stall,
	// queue write side
	input  logic                              q_full,
	output logic                              q_push,
	output logic [TABLE_ADDR_BITS+1:0]        q_phase,
	output lcg_pkg::lcg_flags_t               q_flags
);
	import lcg_pkg::*;

	logic [15:0]           start_phase_q;
	logic [31:0]           first_increment_q;
	logic [31:0]           increment_step_q;
	logic [15:0]           chirp_length_q;
	logic                  repeat_mode_q;

	logic [PHASE_BITS-1:0] phase_acc_q;
	logic [PHASE_BITS-1:0] phase_inc_q;
	logic [15:0]           sample_idx_q;
	logic                  finished_q;

	logic [PHASE_BITS-1:0] rst_acc;
	logic [PHASE_BITS-1:0] rst_inc;
	logic [PHASE_BITS-1:0] step_ext;
	logic [PHASE_BITS-1:0] cur_acc;
	logic [PHASE_BITS-1:0] cur_inc;
	logic [15:0]           cur_idx;
	logic                  cur_fin;
	logic                  last;
	logic                  accept;

	// Decode configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_phase_q     <= '0;
			first_increment_q <= '0;
			increment_step_q  <= '0;
			chirp_length_q    <= CHIRP_LENGTH_RST;
			repeat_mode_q     <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_START_PHASE:     start_phase_q     <= cfg_data[15:0];
				CFG_FIRST_INCREMENT: first_increment_q <= cfg_data;
				CFG_INCREMENT_STEP:  increment_step_q  <= cfg_data;
				CFG_CHIRP_LENGTH:    chirp_length_q    <= cfg_data[15:0];
				CFG_REPEAT_MODE:     repeat_mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Restart values in accumulator width
	assign rst_acc  = PHASE_BITS'(64'(start_phase_q) << (PHASE_BITS - 16));
	assign rst_inc  = PHASE_BITS'(64'(first_increment_q));
	assign step_ext = PHASE_BITS'(64'(signed'(increment_step_q)));

	// A set tick restarts the chirp before this sample is produced
	assign cur_acc = tick ? rst_acc : phase_acc_q;
	assign cur_inc = tick ? rst_inc : phase_inc_q;
	assign cur_idx = tick ? 16'd0 : sample_idx_q;
	assign cur_fin = tick ? 1'b0 : finished_q;
	assign last    = !cur_fin && (cur_idx == 16'(chirp_length_q - 16'd1));

	assign tick_stall = q_full;
	assign accept     = tick_valid && !q_full;

	// Hand the phase and classification to the queue
	assign q_push       = accept;
	assign q_phase      = cur_acc[PHASE_BITS-1 -: TABLE_ADDR_BITS+2];
	assign q_flags.last = last;
	assign q_flags.done = cur_fin;

	// Update the chirp state on every transfer: advance, restart or hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q  <= '0;
			phase_inc_q  <= '0;
			sample_idx_q <= '0;
			finished_q   <= 1'b0;
		end else if (accept) begin
			if (cur_fin) begin
				phase_acc_q  <= cur_acc;
				phase_inc_q  <= cur_inc;
				sample_idx_q <= cur_idx;
				finished_q   <= 1'b1;
			end else if (last) begin
				if (repeat_mode_q) begin
					phase_acc_q  <= rst_acc;
					phase_inc_q  <= rst_inc;
					sample_idx_q <= '0;
					finished_q   <= 1'b0;
				end else begin
					phase_acc_q  <= cur_acc;
					phase_inc_q  <= cur_inc;
					sample_idx_q <= cur_idx;
					finished_q   <= 1'b1;
				end
			end else begin
				phase_acc_q  <= cur_acc + cur_inc;
				phase_inc_q  <= cur_inc + step_ext;
				sample_idx_q <= cur_idx + 16'd1;
				finished_q   <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/lcg_queue.sv
// Short register queue between the front and back parts.
module lcg_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lcg_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full  = (count_q == CNT_BITS'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Store a pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Move the pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule

// File: rtl/lcg_back.sv
// Back part: quadrant mirroring, cosine table read and the output register.
module lcg_back #(
	parameter int TABLE_ADDR_BITS = lcg_pkg::TABLE_ADDR_BITS_DEF,
	parameter int SAMPLE_BITS     = lcg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// queue read side
	input  logic                                q_empty,
	input  logic [TABLE_ADDR_BITS+1:0]          q_phase,
	input  lcg_pkg::lcg_flags_t                 q_flags,
	output logic                                q_pop,
	// sample channel
	output logic                                sample_valid,
	input  logic                                sample_stall,
	output logic signed [SAMPLE_BITS-1:0]       sample,
	output logic                                chirp_end,
	output logic                                done_res
);
	import lcg_pkg::*;

	localparam int TBL_N = 1 << TABLE_ADDR_BITS;
	localparam int MAG_BITS = SAMPLE_BITS - 1;

	typedef logic [MAG_BITS-1:0] rom_t [TBL_N];

	// Quarter-wave cosine by truncated Q30 Taylor series through x^20
	function automatic rom_t build_rom();
		rom_t            tbl;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint unsigned v;
		longint unsigned cap;
		cap = (64'd1 << MAG_BITS) - 64'd1;
		for (int k = 0; k < TBL_N; k++) begin
			x    = (PI_HALF_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
			x2   = (x * x) >> 30;
			term = 64'd1 << 30;
			sum  = 64'sd1 << 30;
			for (int i = 1; i <= 10; i++) begin
				term = (term * x2) >> 30;
				term = term / 64'((2 * i - 1) * (2 * i));
				if ((i % 2) == 1) begin
					sum = sum - signed'(term);
				end else begin
					sum = sum + signed'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			v = ((unsigned'(sum) << MAG_BITS) + (64'd1 << 29)) >> 30;
			if (v > cap) begin
				v = cap;
			end
			tbl[k] = MAG_BITS'(v);
		end
		return tbl;
	endfunction

	localparam rom_t COS_ROM = build_rom();

	logic [TABLE_ADDR_BITS-1:0] idx;
	logic [1:0]                 quad;
	logic                       adv;

	logic                       v_s1;
	logic [TABLE_ADDR_BITS-1:0] addr_s1;
	logic                       neg_s1;
	logic                       zero_s1;
	lcg_flags_t                 flags_s1;

	logic                       v_s2;
	logic [MAG_BITS-1:0]        mag_s2;
	logic                       neg_s2;
	logic                       zero_s2;
	lcg_flags_t                 flags_s2;

	logic                       out_valid_q;
	logic [SAMPLE_BITS-1:0]     sample_q;
	logic                       chirp_end_q;
	logic                       done_q;
	logic [SAMPLE_BITS-1:0]     mag_ext;

	// Whole pipeline moves when the output register is free or taken
	assign adv   = !out_valid_q || !sample_stall;
	assign q_pop = adv && !q_empty;

	assign idx  = q_phase[TABLE_ADDR_BITS-1:0];
	assign quad = q_phase[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];

	// Mirror the index by quadrant
	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1  <= quad[0] ? (TABLE_ADDR_BITS'(0) - idx) : idx;
			zero_s1  <= quad[0] && (idx == '0);
			neg_s1   <= (quad == 2'd1) || (quad == 2'd2);
			flags_s1 <= q_flags;
		end
	end

	// Read the cosine table
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2   <= COS_ROM[addr_s1];
			neg_s2   <= neg_s1;
			zero_s2  <= zero_s1;
			flags_s2 <= flags_s1;
		end
	end

	// Apply sign and the zero cases
	assign mag_ext = {1'b0, mag_s2};

	always_ff @(posedge clk) begin
		if (adv) begin
			if (flags_s2.done || zero_s2) begin
				sample_q <= '0;
			end else if (neg_s2) begin
				sample_q <= SAMPLE_BITS'(0) - mag_ext;
			end else begin
				sample_q <= mag_ext;
			end
			chirp_end_q <= flags_s2.last;
			done_q      <= flags_s2.done;
		end
	end

	// Track stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	assign sample_valid = out_valid_q;
	assign sample       = signed'(sample_q);
	assign chirp_end    = chirp_end_q;
	assign done_res     = done_q;

endmodule
